### sv/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned CntW      = 13;
  localparam logic [CntW-1:0] MaxBuffer   = 13'd4096;
  localparam logic [CntW-1:0] BufferReset = 13'd1024;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned MaxResults = 3;

  localparam logic [20:0] SurrLo   = 21'h00D800;
  localparam logic [20:0] SurrHi   = 21'h00DFFF;
  localparam logic [20:0] BmpMax   = 21'h00FFFF;
  localparam logic [20:0] PointMax = 21'h10FFFF;
  localparam logic [20:0] PlaneOne = 21'h010000;
  localparam logic [5:0]  HiSurrTag = 6'b110110;
  localparam logic [5:0]  LoSurrTag = 6'b110111;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STRAY    = 3'd1,
    ST_BAD_LEAD = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_BAD_CONT = 3'd4,
    ST_SURR     = 3'd5,
    ST_RANGE    = 3'd6,
    ST_FULL     = 3'd7
  } status_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_unit;
    status_e     status;
    logic        run_end;
  } item_t;

  typedef struct packed {
    logic [1:0]            count;
    item_t [MaxResults-1:0] item;
  } res_t;

endpackage

### sv/utf8_to_utf16_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream in, UTF-16 code units and one run status item out.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-----------------------------------
//  in      | in_valid_i / in_ready_o   | in_byte_i, last_byte_i
//  out     | out_valid_o / out_ready_i | code_unit_o, is_unit_o, status_o,
//          |                           | run_end_o
//  config  | cfg_we_i                  | buffer_size_i
//
// One byte per cycle while the queue has room: a byte is registered and
// decoded from that register, and its results are written to the queue.
// The queue drains one result per cycle while out_ready_i is high, so a
// byte giving a surrogate pair or a unit plus status holds the input until
// the queue has room again. Reset clears the run state and sets buffer_size
// to 1024. A stalled output backs up the queue and then the input register.
module utf8_to_utf16_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        is_unit_o,
  output logic [2:0]  status_o,
  output logic        run_end_o,
  input  logic        cfg_we_i,
  input  logic [12:0] buffer_size_i
);
  import u8u16_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       last_q;
  logic       room;
  logic       fire;
  res_t       res;
  item_t      item;

  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      last_q    <= last_byte_i;
    end
  end

  u8u16_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .in_byte_i     (in_byte_q),
    .last_byte_i   (last_q),
    .cfg_we_i      (cfg_we_i),
    .buffer_size_i (buffer_size_i),
    .res_o         (res)
  );

  u8u16_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (item)
  );

  assign code_unit_o = item.code_unit;
  assign is_unit_o   = item.is_unit;
  assign status_o    = item.status;
  assign run_end_o   = item.run_end;

endmodule

### sv/u8u16_core.sv
// ----------------------------------------------------------------------------
// u8u16_core
// Per-byte decode: sequence state, code point assembly, limit checks and
// the result items of one request.
// ----------------------------------------------------------------------------
module u8u16_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   last_byte_i,
  input  logic                   cfg_we_i,
  input  logic [12:0]            buffer_size_i,
  output u8u16_pkg::res_t        res_o
);
  import u8u16_pkg::*;

  logic [CntW-1:0] size_cfg_q;
  logic [20:0]     point_q, point_d;
  logic [1:0]      owed_q, owed_d;
  logic [CntW-1:0] units_q, units_d;
  logic            err_seen_q, err_seen_d;

  logic [CntW-1:0] size_lim, cap;
  logic [CntW:0]   need1, need2;
  logic [20:0]     cp, v;
  logic            complete;
  status_e         err;
  res_t            res;

  assign size_lim = (size_cfg_q > MaxBuffer) ? MaxBuffer : size_cfg_q;
  assign cap      = (size_lim == '0) ? '0 : size_lim - 13'd1;
  assign need1    = {1'b0, units_q} + 14'd1;
  assign need2    = {1'b0, units_q} + 14'd2;

  always_comb begin
    point_d    = point_q;
    owed_d     = owed_q;
    units_d    = units_q;
    err_seen_d = err_seen_q;
    err        = ST_OK;
    complete   = 1'b0;
    cp         = '0;
    v          = '0;
    res        = '0;

    if (err_seen_q) begin
      // drop bytes until the end of the string
      if (last_byte_i) begin
        point_d    = '0;
        owed_d     = '0;
        units_d    = '0;
        err_seen_d = 1'b0;
      end
    end else begin
      if (owed_q == 2'd0) begin
        if (in_byte_i inside {[8'h00:8'h7F]}) begin
          point_d  = {13'd0, in_byte_i};
          complete = 1'b1;
        end else if (in_byte_i inside {[8'h80:8'hBF]}) begin
          err = ST_STRAY;
        end else if (in_byte_i inside {[8'hC0:8'hDF]}) begin
          point_d = {16'd0, in_byte_i[4:0]};
          owed_d  = 2'd1;
        end else if (in_byte_i inside {[8'hE0:8'hEF]}) begin
          point_d = {17'd0, in_byte_i[3:0]};
          owed_d  = 2'd2;
        end else if (in_byte_i inside {[8'hF0:8'hF7]}) begin
          point_d = {18'd0, in_byte_i[2:0]};
          owed_d  = 2'd3;
        end else begin
          err = ST_BAD_LEAD;
        end
      end else if (in_byte_i[7:6] != 2'b10) begin
        err = ST_BAD_CONT;
      end else begin
        point_d  = {point_q[14:0], in_byte_i[5:0]};
        owed_d   = owed_q - 2'd1;
        complete = (owed_q == 2'd1);
      end

      if (complete) begin
        cp = point_d;
        v  = cp - PlaneOne;
        if (cp >= SurrLo && cp <= SurrHi) begin
          err = ST_SURR;
        end else if (cp > PointMax) begin
          err = ST_RANGE;
        end else if (cp <= BmpMax) begin
          if (need1 > {1'b0, cap}) begin
            err = ST_FULL;
          end else begin
            res.item[0].code_unit = cp[15:0];
            res.item[0].is_unit   = 1'b1;
            res.count             = 2'd1;
            units_d               = need1[CntW-1:0];
          end
        end else begin
          if (need2 > {1'b0, cap}) begin
            err = ST_FULL;
          end else begin
            res.item[0].code_unit = {HiSurrTag, v[19:10]};
            res.item[0].is_unit   = 1'b1;
            res.item[1].code_unit = {LoSurrTag, v[9:0]};
            res.item[1].is_unit   = 1'b1;
            res.count             = 2'd2;
            units_d               = need2[CntW-1:0];
          end
        end
        point_d = '0;
      end

      if (err == ST_OK && last_byte_i && owed_d != 2'd0) begin
        err = ST_TRUNC;
      end

      if (err != ST_OK || last_byte_i) begin
        res.item[res.count].status  = err;
        res.item[res.count].run_end = 1'b1;
        res.count                   = res.count + 2'd1;
        point_d                     = '0;
        owed_d                      = '0;
        if (last_byte_i) begin
          units_d    = '0;
          err_seen_d = 1'b0;
        end else begin
          err_seen_d = 1'b1;
        end
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q <= BufferReset;
      point_q    <= '0;
      owed_q     <= '0;
      units_q    <= '0;
      err_seen_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_cfg_q <= buffer_size_i;
      end
      if (fire_i) begin
        point_q    <= point_d;
        owed_q     <= owed_d;
        units_q    <= units_d;
        err_seen_q <= err_seen_d;
      end
    end
  end

endmodule

### sv/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Result queue: takes up to three items per cycle, hands out one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  u8u16_pkg::res_t        res_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output u8u16_pkg::item_t       item_o
);
  import u8u16_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q, count_d;
  logic [1:0]           push_n;
  logic                 pop;

  assign push_n      = push_i ? res_i.count : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign item_o      = mem_q[rd_ptr_q];
  // room for a full burst of results
  assign room_o      = (count_q <= (QueuePtrW+1)'(QueueDepth - MaxResults));
  assign count_d     = count_q + {1'b0, push_n} - {{QueuePtrW{1'b0}}, pop};

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (2'(k) < push_n) begin
        mem_q[wr_ptr_q + QueuePtrW'(k)] <= res_i.item[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_d;
    end
  end

endmodule
